// File: rtl/rss_pkg.sv
// ----------------------------------------------------------------------------
// rss_pkg
// Shared widths, sequencer states and constants for the running sample
// statistics core.
// ----------------------------------------------------------------------------
package rss_pkg;

  localparam int FRAC     = 8;             // fraction bits of scaled outputs
  localparam int COUNT_W  = 32;
  localparam int SAMPLE_W = 32;
  localparam int SUM_W    = 64;
  localparam int SQ_W     = 96;            // sum of squares
  localparam int PROD_W   = 128;           // serial multiplier product
  localparam int MB_W     = 64;            // multiplier serial operand
  localparam int SCALE_W  = 20;
  localparam int DEN_W    = COUNT_W + SCALE_W;
  localparam int OUT_W    = 40;
  localparam int NUM_W    = SUM_W + FRAC;  // divider numerator
  localparam int ROOT_W   = SUM_W + FRAC;  // square root result
  localparam int RAD_W    = 2 * ROOT_W;    // square root argument
  localparam int ITER_W   = 7;             // iteration counters

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ,
    S_UPD,
    S_T,
    S_S2,
    S_DEN,
    S_SQRT,
    S_DMIN,
    S_DMAX,
    S_DMEAN,
    S_DSD,
    S_FIN
  } state_t;

endpackage

// File: rtl/running_sample_statistics_core.sv
// ----------------------------------------------------------------------------
// running_sample_statistics_core
// Running count, min, max, mean and standard deviation of 32-bit samples.
// ----------------------------------------------------------------------------
// One sample beat is taken at a time. The sequencer squares the sample,
// updates the statistics, forms count * sum of squares, the squared sum
// and count * scale_divisor, takes the square root of the spread and then
// divides min, max, mean and the root in turn. The bit-serial multiplier,
// square root and divider are run one after another. A new sample can be
// taken in the cycle after the result is loaded.
// The finished result sits in an output register, so the next sample is
// taken while it waits. A result that is still stalled there when the next
// one is ready holds the sequencer in its last step. Outputs are Q.8,
// divided by scale_divisor (0 acts as 1) and truncated. Once the count is
// saturated, samples are flagged as dropped and leave the statistics
// untouched.
// ----------------------------------------------------------------------------
module running_sample_statistics_core
  import rss_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [SCALE_W-1:0]  cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [SAMPLE_W-1:0] sample,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [COUNT_W-1:0]  sample_count,
  output logic [OUT_W-1:0]    min_scaled,
  output logic [OUT_W-1:0]    max_scaled,
  output logic [OUT_W-1:0]    mean_scaled,
  output logic [OUT_W-1:0]    std_dev_scaled,
  output logic                sample_dropped
);

  state_t state, state_next;
  logic   launched;

  logic [SCALE_W-1:0]  scale;
  logic [SCALE_W-1:0]  scale_eff;
  logic [SAMPLE_W-1:0] samp;
  logic                drop;
  logic [COUNT_W-1:0]  count_reg;
  logic [SUM_W-1:0]    sum_reg;
  logic [SQ_W-1:0]     sum_squares_reg;
  logic [SAMPLE_W-1:0] min_reg;
  logic [SAMPLE_W-1:0] max_reg;
  logic                seen_any;
  logic [PROD_W-1:0]   t_reg;
  logic [PROD_W-1:0]   d_reg;
  logic [DEN_W-1:0]    denom;
  logic [ROOT_W-1:0]   root_reg;
  logic [OUT_W-1:0]    res_min, res_max, res_mean, res_sd;

  logic                mul_start, mul_done;
  logic [SQ_W-1:0]     mul_a;
  logic [MB_W-1:0]     mul_b;
  logic [ITER_W-1:0]   mul_len;
  logic [PROD_W-1:0]   mul_prod;
  logic                div_start, div_done;
  logic [NUM_W-1:0]    div_num;
  logic [ITER_W-1:0]   div_len;
  logic [DEN_W-1:0]    div_den;
  logic [OUT_W-1:0]    div_quot;
  logic                sqrt_start, sqrt_done;
  logic [ROOT_W-1:0]   sqrt_root;
  logic                unit_done;
  logic                out_free;

  assign scale_eff = (scale == '0) ? SCALE_W'(1) : scale;
  assign unit_done = mul_done | div_done | sqrt_done;
  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (state != S_IDLE);

  // serial units
  rss_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .len(mul_len), .prod(mul_prod), .done(mul_done)
  );

  rss_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .len(div_len),
    .den(div_den), .quot(div_quot), .done(div_done)
  );

  rss_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sqrt_start),
    .rad(RAD_W'(d_reg) << (2 * FRAC)), .root(sqrt_root), .done(sqrt_done)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid) state_next = S_SQ;
      S_SQ:    if (unit_done) state_next = S_UPD;
      S_UPD:   state_next = S_T;
      S_T:     if (unit_done) state_next = S_S2;
      S_S2:    if (unit_done) state_next = S_DEN;
      S_DEN:   if (unit_done) state_next = S_SQRT;
      S_SQRT:  if (unit_done) state_next = S_DMIN;
      S_DMIN:  if (unit_done) state_next = S_DMAX;
      S_DMAX:  if (unit_done) state_next = S_DMEAN;
      S_DMEAN: if (unit_done) state_next = S_DSD;
      S_DSD:   if (unit_done) state_next = S_FIN;
      S_FIN:   if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // unit launch and operand select
  always_comb begin
    mul_start  = 1'b0;
    mul_a      = SQ_W'(samp);
    mul_b      = MB_W'(samp);
    mul_len    = ITER_W'(SAMPLE_W);
    div_start  = 1'b0;
    div_num    = NUM_W'(min_reg) << (NUM_W - SAMPLE_W);
    div_len    = ITER_W'(SAMPLE_W + FRAC);
    div_den    = DEN_W'(scale_eff);
    sqrt_start = 1'b0;
    case (state)
      S_SQ: begin
        mul_start = !launched;
      end
      S_T: begin
        mul_start = !launched;
        mul_a     = sum_squares_reg;
        mul_b     = MB_W'(count_reg);
      end
      S_S2: begin
        mul_start = !launched;
        mul_a     = SQ_W'(sum_reg);
        mul_b     = sum_reg;
        mul_len   = ITER_W'(SUM_W);
      end
      S_DEN: begin
        mul_start = !launched;
        mul_a     = SQ_W'(scale_eff);
        mul_b     = MB_W'(count_reg);
      end
      S_SQRT: begin
        sqrt_start = !launched;
      end
      S_DMIN: begin
        div_start = !launched;
      end
      S_DMAX: begin
        div_start = !launched;
        div_num   = NUM_W'(max_reg) << (NUM_W - SAMPLE_W);
      end
      S_DMEAN: begin
        div_start = !launched;
        div_num   = NUM_W'(sum_reg) << FRAC;
        div_len   = ITER_W'(NUM_W);
        div_den   = denom;
      end
      S_DSD: begin
        div_start = !launched;
        div_num   = NUM_W'(root_reg);
        div_len   = ITER_W'(NUM_W);
        div_den   = denom;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      launched  <= 1'b0;
      scale     <= SCALE_W'(1);
      out_valid <= 1'b0;
      count_reg <= '0;
      sum_reg   <= '0;
      sum_squares_reg <= '0;
      min_reg   <= '0;
      max_reg   <= '0;
      seen_any  <= 1'b0;
    end else begin
      state <= state_next;
      if (mul_start || div_start || sqrt_start) launched <= 1'b1;
      else if (unit_done) launched <= 1'b0;
      if (cfg_we) scale <= cfg_wdata;
      if (state == S_FIN && out_free) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      // statistics update
      if (state == S_UPD && !drop) begin
        count_reg       <= count_reg + COUNT_W'(1);
        sum_reg         <= sum_reg + SUM_W'(samp);
        sum_squares_reg <= sum_squares_reg + SQ_W'(mul_prod[SUM_W-1:0]);
        seen_any        <= 1'b1;
        if (!seen_any || samp < min_reg) min_reg <= samp;
        if (!seen_any || samp > max_reg) max_reg <= samp;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      samp <= sample;
      drop <= (count_reg == COUNT_MAX);
    end
    if (state == S_T && mul_done) t_reg <= mul_prod;
    if (state == S_S2 && mul_done) d_reg <= (t_reg >= mul_prod) ? t_reg - mul_prod : '0;
    if (state == S_DEN && mul_done) denom <= mul_prod[DEN_W-1:0];
    if (state == S_SQRT && sqrt_done) root_reg <= sqrt_root;
    if (state == S_DMIN && div_done) res_min <= div_quot;
    if (state == S_DMAX && div_done) res_max <= div_quot;
    if (state == S_DMEAN && div_done) res_mean <= div_quot;
    if (state == S_DSD && div_done) res_sd <= div_quot;
    // result beat
    if (state == S_FIN && out_free) begin
      sample_count   <= count_reg;
      min_scaled     <= res_min;
      max_scaled     <= res_max;
      mean_scaled    <= res_mean;
      std_dev_scaled <= res_sd;
      sample_dropped <= drop;
    end
  end

endmodule

// File: rtl/rss_mul.sv
// ----------------------------------------------------------------------------
// rss_mul
// Shift-and-add multiplier: one bit of the serial operand per cycle.
// ----------------------------------------------------------------------------
module rss_mul
  import rss_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SQ_W-1:0]   a,
  input  logic [MB_W-1:0]   b,
  input  logic [ITER_W-1:0] len,
  output logic [PROD_W-1:0] prod,
  output logic              done
);

  logic [PROD_W-1:0] areg;
  logic [MB_W-1:0]   breg;
  logic [PROD_W-1:0] acc;
  logic [ITER_W-1:0] cnt;
  logic              busy;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == ITER_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // datapath: add shifted multiplicand when the low serial bit is set
  always_ff @(posedge clk) begin
    if (start) begin
      areg <= PROD_W'(a);
      breg <= b;
      acc  <= '0;
      cnt  <= len;
    end else if (busy) begin
      if (breg[0]) acc <= acc + areg;
      areg <= areg << 1;
      breg <= breg >> 1;
      cnt  <= cnt - ITER_W'(1);
    end
  end

  assign prod = acc;

endmodule

// File: rtl/rss_div.sv
// ----------------------------------------------------------------------------
// rss_div
// Restoring divider: one numerator bit per cycle, MSB first, quotient
// saturated to the output width.
// ----------------------------------------------------------------------------
module rss_div
  import rss_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [NUM_W-1:0]  num,   // left aligned
  input  logic [ITER_W-1:0] len,
  input  logic [DEN_W-1:0]  den,
  output logic [OUT_W-1:0]  quot,
  output logic              done
);

  logic [NUM_W-1:0]  nreg;
  logic [DEN_W-1:0]  dreg;
  logic [DEN_W:0]    rem;
  logic [NUM_W-1:0]  q;
  logic [ITER_W-1:0] cnt;
  logic              busy;
  logic [DEN_W+1:0]  rem_sh;
  logic              fits;

  assign rem_sh = {rem, nreg[NUM_W-1]};
  assign fits   = rem_sh >= (DEN_W+2)'(dreg);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == ITER_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      nreg <= num;
      dreg <= den;
      rem  <= '0;
      q    <= '0;
      cnt  <= len;
    end else if (busy) begin
      rem  <= fits ? (DEN_W+1)'(rem_sh - (DEN_W+2)'(dreg)) : (DEN_W+1)'(rem_sh);
      q    <= {q[NUM_W-2:0], fits};
      nreg <= nreg << 1;
      cnt  <= cnt - ITER_W'(1);
    end
  end

  assign quot = (|q[NUM_W-1:OUT_W]) ? '1 : q[OUT_W-1:0];

endmodule

// File: rtl/rss_sqrt.sv
// ----------------------------------------------------------------------------
// rss_sqrt
// Digit-by-digit integer square root: two argument bits per cycle, one
// root bit out.
// ----------------------------------------------------------------------------
module rss_sqrt
  import rss_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [RAD_W-1:0]  rad,
  output logic [ROOT_W-1:0] root,
  output logic              done
);

  logic [RAD_W-1:0]  rreg;
  logic [ROOT_W+1:0] rem;
  logic [ITER_W-1:0] cnt;
  logic              busy;
  logic [ROOT_W+3:0] rem_sh;
  logic [ROOT_W+3:0] trial;
  logic              fits;

  assign rem_sh = {rem, rreg[RAD_W-1:RAD_W-2]};
  assign trial  = (ROOT_W+4)'({root, 2'b01});
  assign fits   = rem_sh >= trial;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == ITER_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rreg <= rad;
      rem  <= '0;
      root <= '0;
      cnt  <= ITER_W'(ROOT_W);
    end else if (busy) begin
      rem  <= fits ? (ROOT_W+2)'(rem_sh - trial) : (ROOT_W+2)'(rem_sh);
      root <= {root[ROOT_W-2:0], fits};
      rreg <= rreg << 2;
      cnt  <= cnt - ITER_W'(1);
    end
  end

endmodule

// File: verif/tb_running_sample_statistics_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_running_sample_statistics_core
// Self-checking bench for the running sample statistics core. Samples are
// pushed through the valid/stall input port while the source inserts random
// idle gaps and the result side random stall bursts. A local model of the
// count, sum, sum of squares, min and max predicts every result beat, and
// the result is checked field by field. The scale divisor is rewritten
// between groups of samples, only while the core is idle.
module tb_running_sample_statistics_core;
  import rss_pkg::*;

  localparam int SETTLE     = 600;      // cycles waited once no result is pending
  localparam int CYCLE_CAP  = 3000000;
  localparam logic [OUT_W-1:0] OUT_SAT = '1;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [SCALE_W-1:0]  cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [SAMPLE_W-1:0] sample = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [COUNT_W-1:0]  sample_count;
  logic [OUT_W-1:0]    min_scaled;
  logic [OUT_W-1:0]    max_scaled;
  logic [OUT_W-1:0]    mean_scaled;
  logic [OUT_W-1:0]    std_dev_scaled;
  logic                sample_dropped;

  typedef struct {
    logic [COUNT_W-1:0] cnt;
    logic [OUT_W-1:0]   mn;
    logic [OUT_W-1:0]   mx;
    logic [OUT_W-1:0]   mean;
    logic [OUT_W-1:0]   sd;
    logic               dropped;
  } stats_t;

  // model state of the accumulator
  logic [COUNT_W-1:0]  acc_count;
  logic [SUM_W-1:0]    acc_sum;
  logic [SQ_W-1:0]     acc_sumsq;
  logic [SAMPLE_W-1:0] acc_min;
  logic [SAMPLE_W-1:0] acc_max;
  logic                acc_seen;
  logic [SCALE_W-1:0]  acc_scale;

  stats_t pending_stats[$];
  int     errors = 0;
  int     cycles = 0;
  bit     quiet = 1'b0;             // no stall bursts or idle gaps when set
  int     out_hold = 0;

  running_sample_statistics_core DUT (
    .clk, .rst, .cfg_we, .cfg_wdata, .in_valid, .in_stall, .sample,
    .out_valid, .out_stall, .sample_count, .min_scaled, .max_scaled,
    .mean_scaled, .std_dev_scaled, .sample_dropped
  );

  always #5 clk = ~clk;

  // hard stop
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // floor square root of a value below 2^192
  function automatic logic [191:0] floor_sqrt(logic [191:0] x);
    logic [191:0] root;
    logic [191:0] cand;
    root = '0;
    for (int b = 95; b >= 0; b--) begin
      cand = root | (192'd1 << b);
      if (cand * cand <= x) root = cand;
    end
    return root;
  endfunction

  function automatic logic [OUT_W-1:0] sat_div(logic [191:0] num, logic [191:0] den);
    logic [191:0] q;
    q = num / den;
    return (q > OUT_SAT) ? OUT_SAT : q[OUT_W-1:0];
  endfunction

  // fold one sample into the model and build the expected result beat
  function automatic stats_t accumulate(logic [SAMPLE_W-1:0] s);
    stats_t r;
    logic [191:0] scl, den, spread;
    scl = (acc_scale == '0) ? 192'd1 : 192'(acc_scale);
    r.dropped = (acc_count == COUNT_MAX);
    if (!r.dropped) begin
      acc_count = acc_count + COUNT_W'(1);
      acc_sum   = acc_sum + SUM_W'(s);
      acc_sumsq = acc_sumsq + SQ_W'(64'(s) * 64'(s));
      if (!acc_seen || s < acc_min) acc_min = s;
      if (!acc_seen || s > acc_max) acc_max = s;
      acc_seen = 1'b1;
    end
    r.cnt  = acc_count;
    r.mn   = sat_div(192'(acc_min) << FRAC, scl);
    r.mx   = sat_div(192'(acc_max) << FRAC, scl);
    r.mean = '0;
    r.sd   = '0;
    if (acc_count != 0) begin
      den    = 192'(acc_count) * scl;
      r.mean = sat_div(192'(acc_sum) << FRAC, den);
      if (192'(acc_count) * 192'(acc_sumsq) >= 192'(acc_sum) * 192'(acc_sum))
        spread = 192'(acc_count) * 192'(acc_sumsq) - 192'(acc_sum) * 192'(acc_sum);
      else
        spread = '0;
      r.sd = sat_div(floor_sqrt(spread << (2 * FRAC)), den);
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
    if (errors < 20)
      $display("mismatch %s at beat %0d: expected %0h got %0h",
               what, sample_count, want, got);
    errors++;
  endtask

  // result side: random stall bursts
  always @(posedge clk) begin
    if (out_hold > 0) begin
      out_hold <= out_hold - 1;
      out_stall <= 1'b1;
    end else if (!quiet && !rst && $urandom_range(0, 3) == 0) begin
      out_hold <= $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result checker: a beat seen valid and unstalled mid-cycle is taken next edge
  always @(negedge clk) begin
    stats_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_stats.size() == 0) begin
        report_mismatch("unexpected beat", 64'(0), 64'(sample_count));
      end else begin
        e = pending_stats.pop_front();
        if (sample_count !== e.cnt)
          report_mismatch("sample_count", 64'(e.cnt), 64'(sample_count));
        if (min_scaled !== e.mn)
          report_mismatch("min_scaled", 64'(e.mn), 64'(min_scaled));
        if (max_scaled !== e.mx)
          report_mismatch("max_scaled", 64'(e.mx), 64'(max_scaled));
        if (mean_scaled !== e.mean)
          report_mismatch("mean_scaled", 64'(e.mean), 64'(mean_scaled));
        if (std_dev_scaled !== e.sd)
          report_mismatch("std_dev_scaled", 64'(e.sd), 64'(std_dev_scaled));
        if (sample_dropped !== e.dropped)
          report_mismatch("sample_dropped", 64'(e.dropped), 64'(sample_dropped));
      end
    end
  end

  // push one sample beat, with an optional idle burst once the core is free
  task automatic send_sample(logic [SAMPLE_W-1:0] s);
    int gap;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    if (gap > 0) begin
      do @(negedge clk); while (in_stall);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= s;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    pending_stats.push_back(accumulate(s));
    in_valid <= 1'b0;
    // core is busy after taking a beat
    @(posedge clk);
  endtask

  // write the scale divisor once the core has drained
  task automatic write_scale(logic [SCALE_W-1:0] v);
    wait (pending_stats.size() == 0);
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    acc_scale = v;
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 255);
      2: return 32'hFFFF_FFFF - $urandom_range(0, 1000);
      3: return 32'h1 << $urandom_range(0, 31);
      4: return acc_min;
      default: return $urandom() >> $urandom_range(0, 31);
    endcase
  endfunction

  // zero as first sample, field extremes, alternating bit patterns
  task automatic test_extremes();
    logic [SAMPLE_W-1:0] vals[10];
    vals = '{32'h0, 32'hFFFF_FFFF, 32'h1, 32'h8000_0000, 32'hAAAA_AAAA,
             32'h5555_5555, 32'h7FFF_FFFF, 32'hFFFF_FFFE, 32'h0, 32'h0000_0100};
    foreach (vals[i]) send_sample(vals[i]);
  endtask

  // divisor extremes, including zero acting as one
  task automatic test_scale_extremes();
    logic [SCALE_W-1:0] scl[5];
    scl = '{20'd0, 20'hFFFFF, 20'd1000000, 20'd3, 20'd1};
    foreach (scl[i]) begin
      write_scale(scl[i]);
      repeat (3) send_sample($urandom());
    end
  endtask

  // bulk random samples over several divisors
  task automatic test_random_bulk(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 200 == 199) write_scale(SCALE_W'($urandom_range(0, 20'hFFFFF)));
      send_sample(pick_sample());
    end
  endtask

  // back-to-back traffic with no idling on either side
  task automatic test_no_idle(int n);
    write_scale(20'd1);
    quiet = 1'b1;
    for (int i = 0; i < n; i++) send_sample(pick_sample());
  endtask

  initial begin
    acc_count = '0;
    acc_sum   = '0;
    acc_sumsq = '0;
    acc_min   = '0;
    acc_max   = '0;
    acc_seen  = 1'b0;
    acc_scale = 20'd1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_extremes();
    test_scale_extremes();
    test_random_bulk(900);
    test_no_idle(125);

    wait (pending_stats.size() == 0);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/rss_pkg.sv
rtl/rss_mul.sv
rtl/rss_div.sv
rtl/rss_sqrt.sv
rtl/running_sample_statistics_core.sv
verif/tb_running_sample_statistics_core.sv
